### rtl/nptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nptl_pkg
// Shared widths, codes and control types of the nearest point lookup core.
// ----------------------------------------------------------------------------
package nptl_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;

  localparam int POS_W      = 24;  // signed Q15.8 position
  localparam int RAD_W      = 16;  // unsigned Q8.8 radius
  localparam int IDX_W      = 8;   // entry_index / nearest_index
  localparam int CNT_W      = 9;   // entries_in_use register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEPTH_W    = 17;  // holds any table depth up to 65536

  localparam int DIFF_W = POS_W + 1;      // signed coordinate difference
  localparam int MAG_W  = POS_W;          // |difference| stays below 2**24
  localparam int HALF_W = MAG_W / 2;      // multiplier operand split
  localparam int PP_W   = MAG_W + HALF_W; // one partial product
  localparam int SQ_W   = 2 * MAG_W;      // squared magnitude
  localparam int DIST_W = SQ_W + 1;       // sum of two squares
  localparam int MEM_W  = 2 * POS_W + RAD_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 2'd1;

  localparam logic [CNT_W-1:0] ENTRIES_RESET   = 9'd0;
  localparam logic [RAD_W-1:0] THRESHOLD_RESET = 16'd128;

  typedef struct packed {
    logic start;     // latch query position, clear best
    logic write;     // write a table entry
    logic issue;     // read one entry into the pipeline
    logic load_out;  // load the output register
    logic empty;     // result is for an empty table
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

### rtl/nearest_point_table_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_table_lookup_core
// Nearest reference point search over a loadable table of (x, y, radius).
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one table slot; slots at or beyond
// TABLE_DEPTH are ignored. A query item (kind 1) scans entries 0 .. N-1,
// N being entries_in_use capped at TABLE_DEPTH, through a single read port
// of the table memory at one entry per cycle; it then drains a five-stage
// squared-distance pipeline, waits in a state until the pipeline is seen
// idle, and hands the result to the output register, which waits while an
// earlier result is still stalled. The next item is taken once the result
// is handed over. An empty table skips the scan and goes straight to the
// hand-over. Input is stalled while a query runs and during reset.
// The nearest entry is chosen on squared Euclidean distance, the lowest
// index winning a tie, and the result carries its radius, its index and a
// flag that the radius reaches trigger_threshold. Slots read before they
// were ever written return undefined data; the table needs no clearing
// after reset. Write configuration only while no query is in flight.
// ----------------------------------------------------------------------------
module nearest_point_table_lookup_core #(
  parameter int TABLE_DEPTH = nptl_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [nptl_pkg::IDX_W-1:0]            entry_index,
  input  logic signed [nptl_pkg::POS_W-1:0]     pos_x,
  input  logic signed [nptl_pkg::POS_W-1:0]     pos_y,
  input  logic [nptl_pkg::RAD_W-1:0]            entry_radius,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [nptl_pkg::RAD_W-1:0]            found_radius,
  output logic [nptl_pkg::IDX_W-1:0]            nearest_index,
  output logic                                  above_threshold,
  output logic                                  table_empty,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [nptl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nptl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [nptl_pkg::CNT_W-1:0] entries_in_use;
  logic [nptl_pkg::RAD_W-1:0] trigger_threshold;

  nptl_pkg::cmd_t    cmd;
  nptl_pkg::status_t status;
  logic [AW-1:0]     rd_addr;

  // configuration registers; unknown indices drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use    <= nptl_pkg::ENTRIES_RESET;
      trigger_threshold <= nptl_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nptl_pkg::REG_ENTRIES_IN_USE: begin
          entries_in_use <= cfg_data[nptl_pkg::CNT_W-1:0];
        end
        nptl_pkg::REG_TRIGGER_THRESHOLD: begin
          trigger_threshold <= cfg_data[nptl_pkg::RAD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  nptl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .cfg_count (entries_in_use),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .status    (status)
  );

  nptl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .status          (status),
    .entry_index     (entry_index),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .entry_radius    (entry_radius),
    .threshold       (trigger_threshold),
    .found_radius    (found_radius),
    .nearest_index   (nearest_index),
    .above_threshold (above_threshold),
    .table_empty     (table_empty)
  );

  // searched entry count, for the checks below
  logic [nptl_pkg::DEPTH_W-1:0] searched;
  assign searched =
      (nptl_pkg::DEPTH_W'(entries_in_use) > nptl_pkg::DEPTH_W'(TABLE_DEPTH)) ?
      nptl_pkg::DEPTH_W'(TABLE_DEPTH) : nptl_pkg::DEPTH_W'(entries_in_use);

  // an empty-table result carries zeros elsewhere
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_empty |->
      found_radius == '0 && nearest_index == '0 && !above_threshold)
    else $error("empty-table result with non-zero fields");

  // the flag agrees with the radius and the threshold register
  a_thresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_empty |->
      above_threshold == (found_radius >= trigger_threshold))
    else $error("above_threshold disagrees with found_radius");

  // a non-empty result points inside the searched range (checked while at most 256 entries are searched)
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_empty && searched <= nptl_pkg::DEPTH_W'(256) |->
      nptl_pkg::DEPTH_W'(nearest_index) < searched)
    else $error("nearest_index outside the searched entries");

  // an empty-table result only comes from a zero entry count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_empty |-> searched == '0)
    else $error("table_empty with entries in use");

endmodule

### rtl/nptl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nptl_ctrl
// Sequencer: accepts items, walks the table addresses, drains the distance
// pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module nptl_ctrl #(
  parameter int TABLE_DEPTH = nptl_pkg::TABLE_DEPTH_DEFAULT,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [nptl_pkg::CNT_W-1:0]  cfg_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output nptl_pkg::cmd_t              cmd,
  output logic [AW-1:0]               rd_addr,
  input  nptl_pkg::status_t           status
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

  state_t                     state;
  logic [CW-1:0]              count;
  logic                       empty_q;
  logic [nptl_pkg::DEPTH_W-1:0] cnt_wide;
  logic                       accept;
  logic                       last;
  logic                       out_free;

  always_comb begin
    if (nptl_pkg::DEPTH_W'(cfg_count) > nptl_pkg::DEPTH_W'(TABLE_DEPTH)) begin
      cnt_wide = nptl_pkg::DEPTH_W'(TABLE_DEPTH);
    end else begin
      cnt_wide = nptl_pkg::DEPTH_W'(cfg_count);
    end
  end

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last     = (CW'(rd_addr) == count - CW'(1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.start    = accept && (kind == nptl_pkg::KIND_QUERY);
    cmd.write    = accept && (kind == nptl_pkg::KIND_LOAD);
    cmd.issue    = (state == ST_SCAN);
    cmd.load_out = (state == ST_FINISH) && out_free;
    cmd.empty    = empty_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      empty_q   <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      rd_addr   <= '0;
    end else begin
      // output register: set on a fresh result, drop after its transfer
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            count   <= cnt_wide[CW-1:0];
            rd_addr <= '0;
            if (cnt_wide == '0) begin
              empty_q <= 1'b1;
              state   <= ST_FINISH;
            end else begin
              empty_q <= 1'b0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_addr <= rd_addr + AW'(1);
          if (last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/nptl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nptl_datapath
// Table memory, five-stage squared-distance pipeline, running minimum and
// output register.
// ----------------------------------------------------------------------------
module nptl_datapath #(
  parameter int TABLE_DEPTH = nptl_pkg::TABLE_DEPTH_DEFAULT,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  nptl_pkg::cmd_t                     cmd,
  input  logic [AW-1:0]                      rd_addr,
  output nptl_pkg::status_t                  status,
  input  logic [nptl_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [nptl_pkg::POS_W-1:0]  pos_x,
  input  logic signed [nptl_pkg::POS_W-1:0]  pos_y,
  input  logic [nptl_pkg::RAD_W-1:0]         entry_radius,
  input  logic [nptl_pkg::RAD_W-1:0]         threshold,
  output logic [nptl_pkg::RAD_W-1:0]         found_radius,
  output logic [nptl_pkg::IDX_W-1:0]         nearest_index,
  output logic                               above_threshold,
  output logic                               table_empty
);

  localparam int POS_W  = nptl_pkg::POS_W;
  localparam int RAD_W  = nptl_pkg::RAD_W;
  localparam int MAG_W  = nptl_pkg::MAG_W;
  localparam int HALF_W = nptl_pkg::HALF_W;
  localparam int PP_W   = nptl_pkg::PP_W;
  localparam int SQ_W   = nptl_pkg::SQ_W;
  localparam int DIST_W = nptl_pkg::DIST_W;
  localparam int DIFF_W = nptl_pkg::DIFF_W;

  logic [nptl_pkg::MEM_W-1:0] mem [TABLE_DEPTH];
  logic [nptl_pkg::MEM_W-1:0] rd_q;
  logic                       wr_ok;

  logic signed [POS_W-1:0] qx, qy;
  logic v1, v2, v3, v4, v5;
  logic [AW-1:0]    idx1, idx2, idx3, idx4, idx5;
  logic [RAD_W-1:0] r2, r3, r4, r5;
  logic [MAG_W-1:0] adx, ady;
  logic [PP_W-1:0]  pxl, pxh, pyl, pyh;
  logic [SQ_W-1:0]  sqx, sqy;
  logic [DIST_W-1:0] sq_sum;

  logic              best_valid;
  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best_idx;
  logic [RAD_W-1:0]  best_r;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [DIFF_W-1:0] ndx, ndy;
  logic signed [POS_W-1:0]  ex, ey;
  logic [AW+nptl_pkg::IDX_W-1:0] idx_ext;

  assign wr_ok = nptl_pkg::DEPTH_W'(entry_index) < nptl_pkg::DEPTH_W'(TABLE_DEPTH);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[AW'(entry_index)] <= {pos_x, pos_y, entry_radius};
    end
    if (cmd.issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign ex  = rd_q[2*POS_W+RAD_W-1 -: POS_W];
  assign ey  = rd_q[POS_W+RAD_W-1 -: POS_W];
  assign dx  = {qx[POS_W-1], qx} - {ex[POS_W-1], ex};
  assign dy  = {qy[POS_W-1], qy} - {ey[POS_W-1], ey};
  assign ndx = -dx;
  assign ndy = -dy;

  assign status.pipe_busy = v1 | v2 | v3 | v4 | v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
      best_valid <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.start) begin
        best_valid <= 1'b0;
      end else if (v5) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= pos_x;
      qy <= pos_y;
    end
    idx1 <= rd_addr;
    // stage A: magnitudes of the differences
    adx  <= dx[DIFF_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
    ady  <= dy[DIFF_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
    idx2 <= idx1;
    r2   <= rd_q[RAD_W-1:0];
    // stage B: half-width partial products
    pxl  <= PP_W'(adx) * PP_W'(adx[HALF_W-1:0]);
    pxh  <= PP_W'(adx) * PP_W'(adx[MAG_W-1:HALF_W]);
    pyl  <= PP_W'(ady) * PP_W'(ady[HALF_W-1:0]);
    pyh  <= PP_W'(ady) * PP_W'(ady[MAG_W-1:HALF_W]);
    idx3 <= idx2;
    r3   <= r2;
    // stage C: recombine into squares
    sqx  <= SQ_W'(pxl) + (SQ_W'(pxh) << HALF_W);
    sqy  <= SQ_W'(pyl) + (SQ_W'(pyh) << HALF_W);
    idx4 <= idx3;
    r4   <= r3;
    // stage D: squared distance
    sq_sum <= DIST_W'(sqx) + DIST_W'(sqy);
    idx5 <= idx4;
    r5   <= r4;
    // stage E: keep the strict minimum, so the lowest index wins a tie
    if (v5 && (!best_valid || sq_sum < best_d)) begin
      best_d   <= sq_sum;
      best_idx <= idx5;
      best_r   <= r5;
    end
  end

  assign idx_ext = (AW + nptl_pkg::IDX_W)'(best_idx);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      table_empty <= cmd.empty;
      if (cmd.empty) begin
        found_radius    <= '0;
        nearest_index   <= '0;
        above_threshold <= 1'b0;
      end else begin
        found_radius    <= best_r;
        nearest_index   <= idx_ext[nptl_pkg::IDX_W-1:0];
        above_threshold <= (best_r >= threshold);
      end
    end
  end

endmodule
